@@ hw/rtl/crt_pkg.sv @@
package crt_pkg;

   // Command bytes
   localparam logic [7:0] CMD_SET_TIME   = 8'hFE;
   localparam logic [7:0] CMD_END_SECURE = 8'hFD;

   // Command parser phases
   localparam logic [1:0] PHASE_WAIT   = 2'd0;
   localparam logic [1:0] PHASE_FIRST  = 2'd1;
   localparam logic [1:0] PHASE_SECOND = 2'd2;

   // Input beat kinds
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Register indexes
   localparam logic [1:0] CSR_MIN_RESTART_TIME = 2'd0;
   localparam logic [1:0] CSR_TICKS_PER_UNIT   = 2'd1;
   localparam logic [1:0] CSR_PERIODS_TO_FIRE  = 2'd2;
   localparam logic [1:0] CSR_PULSE_TICKS      = 2'd3;

   // Reset values
   localparam logic [15:0] RST_MIN_RESTART_TIME = 16'd100;
   localparam logic [3:0]  RST_TICKS_PER_UNIT   = 4'd5;
   localparam logic [7:0]  RST_PERIODS_TO_FIRE  = 8'd200;
   localparam logic [15:0] RST_PULSE_TICKS      = 16'd10000;
   localparam logic [15:0] RST_RESTART_TIME     = 16'd10000;

   localparam int TICK_W = 20;

   typedef struct packed {
      logic [15:0] min_restart_time;
      logic [3:0]  ticks_per_unit;
      logic [7:0]  periods_to_fire;
      logic [15:0] pulse_ticks;
   } cfg_type;

   typedef struct packed {
      logic restart_line;
      logic secure_line;
      logic armed;
      logic fired;
      logic time_loaded;
   } result_type;

endpackage

@@ hw/rtl/crt_cmd.sv @@
module crt_cmd import crt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_en,
   input  logic [7:0]  rx_byte,
   input  logic [15:0] min_restart_time,
   output logic [15:0] restart_time,
   output logic        load
);

   logic [1:0]  phase_ff, phase_in;
   logic [7:0]  high_ff, high_in;
   logic [15:0] time_ff, time_in;
   logic [15:0] cmd_time;

   assign cmd_time = {high_ff, rx_byte};

   // Decode the byte against the current phase
   always_comb begin
      phase_in = phase_ff;
      high_in  = high_ff;
      time_in  = time_ff;
      load     = 1'b0;
      if (byte_en) begin
         if (rx_byte == CMD_SET_TIME) begin
            phase_in = PHASE_FIRST;
         end else if (rx_byte != CMD_END_SECURE) begin
            unique case (phase_ff)
               PHASE_FIRST: begin
                  high_in  = rx_byte;
                  phase_in = PHASE_SECOND;
               end
               PHASE_SECOND: begin
                  // clamp up to the minimum
                  time_in  = (cmd_time < min_restart_time) ? min_restart_time : cmd_time;
                  phase_in = PHASE_WAIT;
                  load     = 1'b1;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_WAIT;
         high_ff  <= 8'd0;
         time_ff  <= RST_RESTART_TIME;
      end else begin
         phase_ff <= phase_in;
         high_ff  <= high_in;
         time_ff  <= time_in;
      end
   end

   // The timer sees the time that this beat leaves behind
   assign restart_time = time_in;

endmodule

@@ hw/rtl/crt_timer.sv @@
module crt_timer import crt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        tick_en,
   input  logic        load,
   input  logic [15:0] restart_time,
   input  cfg_type     cfg,
   output result_type  status
);

   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [7:0]        periods_ff, periods_in;
   logic              armed_ff, armed_in;
   logic [15:0]       pulse_ff, pulse_in;
   logic              restart_ff, restart_in;
   logic              secure_ff, secure_in;
   logic              fired;
   logic [TICK_W-1:0] last_tick;
   logic [7:0]        periods_inc;

   // Last tick index of a period: ticks_per_unit * restart_time
   assign last_tick   = TICK_W'(cfg.ticks_per_unit) * TICK_W'(restart_time);
   assign periods_inc = periods_ff + 8'd1;

   always_comb begin
      tick_in    = tick_ff;
      periods_in = periods_ff;
      armed_in   = armed_ff;
      pulse_in   = pulse_ff;
      restart_in = restart_ff;
      secure_in  = secure_ff;
      fired      = 1'b0;
      if (tick_en) begin
         // run down the pulse, raise the line at its end
         if (pulse_ff != 16'd0) begin
            pulse_in = pulse_ff - 16'd1;
            if (pulse_ff == 16'd1) begin
               restart_in = 1'b1;
            end
         end
         // advance the period count while armed
         if (armed_ff) begin
            if (tick_ff >= last_tick) begin
               tick_in    = '0;
               periods_in = periods_inc;
               if (periods_inc == cfg.periods_to_fire) begin
                  armed_in   = 1'b0;
                  secure_in  = 1'b0;
                  fired      = 1'b1;
                  pulse_in   = cfg.pulse_ticks;
                  restart_in = (cfg.pulse_ticks == 16'd0);
               end
            end else begin
               tick_in = tick_ff + TICK_W'(1);
            end
         end
      end else if (load) begin
         // re-arm with cleared counts
         tick_in    = '0;
         periods_in = 8'd0;
         armed_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         periods_ff <= 8'd0;
         armed_ff   <= 1'b0;
         pulse_ff   <= 16'd0;
         restart_ff <= 1'b1;
         secure_ff  <= 1'b1;
      end else begin
         tick_ff    <= tick_in;
         periods_ff <= periods_in;
         armed_ff   <= armed_in;
         pulse_ff   <= pulse_in;
         restart_ff <= restart_in;
         secure_ff  <= secure_in;
      end
   end

   assign status.restart_line = restart_in;
   assign status.secure_line  = secure_in;
   assign status.armed        = armed_in;
   assign status.fired        = fired;
   assign status.time_loaded  = load;

endmodule

@@ hw/rtl/commanded_restart_timer.sv @@
// Pipeline: an accepted beat passes the input register, then the result
// register, whose contents drive rsp_*.
// Throughput: one beat per cycle while rsp_stall does not hold the result
// register; every beat, byte or tick, updates the parser and timer state as it steps.
// Reset: synchronous, active high; returns parser, timer and config state to
// their default values and empties both stages; beat and result data are not reset.
module commanded_restart_timer import crt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_restart_line,
   output logic        rsp_secure_line,
   output logic        rsp_armed,
   output logic        rsp_fired,
   output logic        rsp_time_loaded,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type     cfg_ff;
   logic        in_valid_ff;
   logic        in_op_ff;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff;
   result_type  out_ff;
   result_type  status;
   logic        advance;
   logic        step;
   logic        take;
   logic [15:0] restart_time;
   logic        load;

   assign csr_ready = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_restart_time <= RST_MIN_RESTART_TIME;
         cfg_ff.ticks_per_unit   <= RST_TICKS_PER_UNIT;
         cfg_ff.periods_to_fire  <= RST_PERIODS_TO_FIRE;
         cfg_ff.pulse_ticks      <= RST_PULSE_TICKS;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_RESTART_TIME: cfg_ff.min_restart_time <= csr_data;
            CSR_TICKS_PER_UNIT:   cfg_ff.ticks_per_unit   <= csr_data[3:0];
            CSR_PERIODS_TO_FIRE:  cfg_ff.periods_to_fire  <= csr_data[7:0];
            CSR_PULSE_TICKS:      cfg_ff.pulse_ticks      <= csr_data;
            default:              cfg_ff.pulse_ticks      <= cfg_ff.pulse_ticks;
         endcase
      end
   end

   // Handshake: the result register frees up when empty or taken
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_rx_byte;
      end
   end

   crt_cmd u_cmd (
      .clock            (clock),
      .reset            (reset),
      .byte_en          (step && (in_op_ff == OP_BYTE)),
      .rx_byte          (in_byte_ff),
      .min_restart_time (cfg_ff.min_restart_time),
      .restart_time     (restart_time),
      .load             (load)
   );

   crt_timer u_timer (
      .clock        (clock),
      .reset        (reset),
      .tick_en      (step && (in_op_ff == OP_TICK)),
      .load         (load),
      .restart_time (restart_time),
      .cfg          (cfg_ff),
      .status       (status)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_ff <= status;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_restart_line = out_ff.restart_line;
   assign rsp_secure_line  = out_ff.secure_line;
   assign rsp_armed        = out_ff.armed;
   assign rsp_fired        = out_ff.fired;
   assign rsp_time_loaded  = out_ff.time_loaded;

endmodule

@@ sim/tb_commanded_restart_timer.sv @@
`timescale 1ns / 100ps

module tb_commanded_restart_timer;
   import crt_pkg::*;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = OP_TICK;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_restart_line;
   logic        rsp_secure_line;
   logic        rsp_armed;
   logic        rsp_fired;
   logic        rsp_time_loaded;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MIN_RESTART_TIME;
   logic [15:0] csr_data = 16'h0000;

   // beats waiting to go out, and line levels still owed by the block
   req_beat_type beats_to_send[$];
   result_type   levels_due[$];
   int         faults = 0;
   int         results_seen = 0;
   int         send_wait = 0;
   int         send_calm = 0;
   int         hold_left = 0;
   int         hold_calm = 0;

   // timer state as the block should hold it
   cfg_type     model_cfg;
   logic [1:0]  cmd_step;
   logic [7:0]  hi_half;
   logic [15:0] unit_time;
   logic [19:0] tick_count;
   logic [7:0]  period_count;
   logic        counting;
   logic [15:0] pulse_count;
   logic        restart_lvl;
   logic        secure_lvl;

   commanded_restart_timer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_restart_line (rsp_restart_line),
      .rsp_secure_line  (rsp_secure_line),
      .rsp_armed        (rsp_armed),
      .rsp_fired        (rsp_fired),
      .rsp_time_loaded  (rsp_time_loaded),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   // Apply one byte or tick to the timer state and return the line levels after it
   function automatic result_type advance_timer(input logic op, input logic [7:0] rx);
      result_type r;
      logic [15:0] t;
      int span;
      r = '0;
      if (op == OP_BYTE) begin
         if (rx == CMD_SET_TIME) begin
            cmd_step = PHASE_FIRST;
         end else if (rx != CMD_END_SECURE) begin
            if (cmd_step == PHASE_FIRST) begin
               hi_half = rx;
               cmd_step = PHASE_SECOND;
            end else if (cmd_step == PHASE_SECOND) begin
               t = {hi_half, rx};
               if (t < model_cfg.min_restart_time) t = model_cfg.min_restart_time;
               unit_time = t;
               cmd_step = PHASE_WAIT;
               tick_count = '0;
               period_count = '0;
               counting = 1'b1;
               r.time_loaded = 1'b1;
            end
         end
      end else begin
         // pulse countdown runs whether armed or not
         if (pulse_count != 0) begin
            pulse_count = pulse_count - 16'd1;
            if (pulse_count == 0) restart_lvl = 1'b1;
         end
         if (counting) begin
            span = int'(model_cfg.ticks_per_unit) * int'(unit_time) + 1;
            if (int'(tick_count) + 1 >= span) begin
               tick_count = '0;
               period_count = period_count + 8'd1;
               if (period_count == model_cfg.periods_to_fire) begin
                  counting = 1'b0;
                  secure_lvl = 1'b0;
                  r.fired = 1'b1;
                  pulse_count = model_cfg.pulse_ticks;
                  restart_lvl = (model_cfg.pulse_ticks == 0);
               end
            end else begin
               tick_count = tick_count + 20'd1;
            end
         end
      end
      r.restart_line = restart_lvl;
      r.secure_line = secure_lvl;
      r.armed = counting;
      return r;
   endfunction

   // Wait cycles before the next beat; now and then a burst with no waiting at all
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 50);
         return 0;
      end
      return $urandom_range(0, 15);
   endfunction

   task automatic flag_fault(input string msg);
      faults++;
      if (faults <= 10) $display("%0t: %s", $realtime, msg);
   endtask

   // Sender: present queued beats, hold while stalled, idle between beats
   always @(posedge clock) begin
      req_beat_type b;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            levels_due.push_back(advance_timer(req_op, req_rx_byte));
            send_wait = draw_wait(send_calm);
         end
         if (!(req_valid && req_stall)) begin
            if (send_wait != 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (beats_to_send.size() != 0) begin
               b = beats_to_send.pop_front();
               req_op <= b.op;
               req_rx_byte <= b.rx_byte;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: take results, compare against the oldest owed levels, stall at random
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_restart_line, rsp_secure_line, rsp_armed, rsp_fired, rsp_time_loaded};
            if (levels_due.size() == 0) begin
               flag_fault($sformatf("result %0d arrived with nothing owed", results_seen));
            end else begin
               want = levels_due.pop_front();
               if (got !== want)
                  flag_fault($sformatf({"result %0d: want rst=%b sec=%b arm=%b fire=%b ",
                     "load=%b, got rst=%b sec=%b arm=%b fire=%b load=%b"}, results_seen,
                     want.restart_line, want.secure_line, want.armed, want.fired,
                     want.time_loaded, got.restart_line, got.secure_line, got.armed,
                     got.fired, got.time_loaded));
            end
            results_seen++;
            hold_left = draw_wait(hold_calm);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic push_byte(input logic [7:0] v);
      beats_to_send.push_back('{op: OP_BYTE, rx_byte: v});
   endtask

   task automatic push_ticks(input int n);
      repeat (n) beats_to_send.push_back('{op: OP_TICK, rx_byte: 8'($urandom)});
   endtask

   task automatic push_command(input logic [7:0] hi, input logic [7:0] lo);
      push_byte(CMD_SET_TIME);
      push_byte(hi);
      push_byte(lo);
   endtask

   // Drain everything in flight so the block sits idle; look between edges so
   // the sender's updates from the last edge have landed
   task automatic settle();
      do @(negedge clock);
      while (beats_to_send.size() != 0 || levels_due.size() != 0 || req_valid);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MIN_RESTART_TIME: model_cfg.min_restart_time = val;
         CSR_TICKS_PER_UNIT:   model_cfg.ticks_per_unit = val[3:0];
         CSR_PERIODS_TO_FIRE:  model_cfg.periods_to_fire = val[7:0];
         CSR_PULSE_TICKS:      model_cfg.pulse_ticks = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [15:0] min_t, input logic [15:0] tpu,
                             input logic [15:0] ptf, input logic [15:0] pulse);
      settle();
      write_reg(CSR_MIN_RESTART_TIME, min_t);
      write_reg(CSR_TICKS_PER_UNIT, tpu);
      write_reg(CSR_PERIODS_TO_FIRE, ptf);
      write_reg(CSR_PULSE_TICKS, pulse);
   endtask

   // Mostly well-formed set-time commands and tick runs, plus stray and broken bytes
   task automatic queue_random_beats(input int n, input int max_lo);
      int left;
      int pick;
      int k;
      left = n;
      while (left > 0) begin
         pick = $urandom_range(0, 99);
         if (pick < 14) begin
            push_byte(CMD_SET_TIME);
            if ($urandom_range(0, 9) == 0) push_byte(CMD_END_SECURE);
            push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
            push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(0, max_lo)));
            left -= 3;
         end else if (pick < 18) begin
            // command cut short: whatever follows lands in the middle of it
            push_byte(CMD_SET_TIME);
            push_byte(8'($urandom));
            left -= 2;
         end else if (pick < 26) begin
            push_byte(8'($urandom));
            left--;
         end else begin
            k = $urandom_range(1, 24);
            push_ticks(k);
            left -= k;
         end
      end
   endtask

   initial begin
      model_cfg.min_restart_time = RST_MIN_RESTART_TIME;
      model_cfg.ticks_per_unit = RST_TICKS_PER_UNIT;
      model_cfg.periods_to_fire = RST_PERIODS_TO_FIRE;
      model_cfg.pulse_ticks = RST_PULSE_TICKS;
      cmd_step = PHASE_WAIT;
      hi_half = 8'h00;
      unit_time = RST_RESTART_TIME;
      tick_count = '0;
      period_count = '0;
      counting = 1'b0;
      pulse_count = '0;
      restart_lvl = 1'b1;
      secure_lvl = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Defaults: idle tick, stray bytes, clamp, full-scale time, restart mid-command
      push_ticks(1);
      push_byte(8'h00);
      push_byte(CMD_END_SECURE);
      push_command(8'h00, 8'h05);
      push_ticks(1);
      push_byte(CMD_SET_TIME);
      push_byte(CMD_END_SECURE);
      push_byte(8'hFF);
      push_byte(8'hFF);
      push_byte(CMD_SET_TIME);
      push_byte(8'h12);
      push_command(8'h80, 8'h01);
      push_byte(8'h7F);
      push_ticks(1);

      // One-tick periods: fire with no pulse, then fire again while a pulse runs
      set_config(16'd0, 16'd0, 16'd1, 16'd0);
      push_command(8'h00, 8'h00);
      push_ticks(2);
      set_config(16'd0, 16'd0, 16'd1, 16'd3);
      push_command(8'h00, 8'h00);
      push_ticks(1);
      push_command(8'h00, 8'h00);
      push_ticks(5);

      set_config(16'd0, 16'd1, 16'd2, 16'd3);
      queue_random_beats(110, 4);

      // Register extremes: every time clamps high, nothing fires
      set_config(16'hFFFF, 16'd15, 16'd255, 16'hFFFF);
      queue_random_beats(50, 255);

      // Zero fire count wraps to 256 periods
      set_config(16'd0, 16'd0, 16'd0, 16'd1);
      push_command(8'h00, 8'h00);
      push_ticks(260);
      queue_random_beats(60, 4);

      // Lower the fire count below the running count while armed
      set_config(16'd0, 16'd0, 16'd10, 16'd2);
      push_command(8'h00, 8'h00);
      push_ticks(5);
      settle();
      write_reg(CSR_PERIODS_TO_FIRE, 16'd2);
      push_ticks(255);

      set_config(16'd2, 16'd2, 16'd3, 16'd0);
      queue_random_beats(110, 3);

      repeat (2) begin
         set_config(16'($urandom_range(0, 4)), 16'($urandom_range(1, 3)),
                    16'($urandom_range(1, 4)), 16'($urandom_range(0, 30)));
         queue_random_beats(130, 5);
      end

      settle();
      repeat (10) @(posedge clock);
      if (levels_due.size() != 0)
         flag_fault($sformatf("%0d results never arrived", levels_due.size()));
      if (faults == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
